@@ rtl/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg: shared definitions of the lottery draw scheduler
// Field widths, default sizes and the link record passed from cell to cell.
// ----------------------------------------------------------------------------
package lds_pkg;

    // default sizes
    localparam int NUM_JOBS_DEF  = 8;
    localparam int WIN_WIDTH_DEF = 16;

    // fixed field widths
    localparam int TICKETS_W  = 8;   // ticket count of one job
    localparam int DRAW_W     = 31;  // random draw
    localparam int TICKET_W   = 11;  // running sums and winning ticket
    localparam int INDEX_W    = 3;   // job index
    localparam int WINS_OUT_W = 16;  // reported win count
    localparam int CFG_IDX_W  = 4;   // register index on the config port

    // running sum and found flag handed down the row of cells
    typedef struct packed {
        logic [TICKET_W-1:0] sum;
        logic                found;
    } lds_link_t;

endpackage

@@ rtl/lds_cell.sv @@
// ----------------------------------------------------------------------------
// lds_cell: one job slot of the scheduler
// Holds the job's ticket count and win counter, adds its tickets to the
// running sum from its left neighbor and registers the result for the next.
// ----------------------------------------------------------------------------
module lds_cell #(
    parameter int WIN_WIDTH = lds_pkg::WIN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lds_pkg::TICKETS_W-1:0] cfg_data,
    input  lds_pkg::lds_link_t            link_in,
    output lds_pkg::lds_link_t            link_out,
    input  logic [lds_pkg::TICKET_W-1:0]  ticket,
    input  logic                          grant,
    output logic                          hit,
    output logic [WIN_WIDTH-1:0]          wins
);
    import lds_pkg::*;

    localparam logic [WIN_WIDTH-1:0] WIN_MAX = '1;

    logic [TICKETS_W-1:0] tickets_reg;
    lds_link_t            link_reg;
    lds_link_t            link_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [WIN_WIDTH-1:0] wins_reg;
    logic [WIN_WIDTH-1:0] wins_next;

    // running sum, first-hit detection and saturating win count
    always_comb
    begin
        link_next.sum   = link_in.sum + TICKET_W'(tickets_reg);
        hit_next        = !link_in.found && (link_next.sum > ticket);
        link_next.found = link_in.found | hit_next;
        wins_next       = wins_reg;
        if (grant && hit_reg && (wins_reg != WIN_MAX))
        begin
            wins_next = wins_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tickets_reg <= '0;
            link_reg    <= '0;
            hit_reg     <= 1'b0;
            wins_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tickets_reg <= cfg_data;
            end
            link_reg <= link_next;
            hit_reg  <= hit_next;
            wins_reg <= wins_next;
        end
    end

    assign link_out = link_reg;
    assign hit      = hit_reg;
    assign wins     = wins_reg;

endmodule

@@ rtl/lds_divmod.sv @@
// ----------------------------------------------------------------------------
// lds_divmod: serial remainder unit
// Restoring division, one draw bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module lds_divmod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lds_pkg::DRAW_W-1:0]   dividend,
    input  logic [lds_pkg::TICKET_W-1:0] divisor,
    output logic                         busy,
    output logic [lds_pkg::TICKET_W-1:0] remainder
);
    import lds_pkg::*;

    localparam int STEP_W = $clog2(DRAW_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DRAW_W - 1);

    logic [DRAW_W-1:0]   dvd_reg;
    logic [DRAW_W-1:0]   dvd_next;
    logic [TICKET_W-1:0] rem_reg;
    logic [TICKET_W-1:0] rem_next;
    logic [TICKET_W-1:0] dvs_reg;
    logic [TICKET_W-1:0] dvs_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                busy_reg;
    logic                busy_next;
    logic [TICKET_W:0]   trial;
    logic                fits;

    // one shift-and-subtract step per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DRAW_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? TICKET_W'(trial - {1'b0, dvs_reg}) : trial[TICKET_W-1:0];
            dvd_next  = {dvd_reg[DRAW_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/lottery_draw_scheduler.sv @@
// ----------------------------------------------------------------------------
// lottery_draw_scheduler: lottery arbiter over NUM_JOBS jobs
// Each job owns a ticket count; every draw picks a job with probability
// proportional to its tickets and bumps that job's win counter.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the ticket
//   count of job cfg_index; always ready, indexes without a job are dropped.
//   in channel (in_valid/in_ready, random_value) takes one draw item.
//   out channel (out_valid/out_ready) returns winner_index, winning_ticket,
//   winner_wins and no_tickets for each draw, in order.
// Sequence:
//   one draw at a time; each draw runs the sum pass through the cell row,
//   the serial remainder unit (one draw bit per cycle), the selection pass
//   and the result load, in that order, and skips from the sum pass to the
//   result load when no job holds tickets. in_ready rises together with
//   out_valid, once the result is loaded into the output register.
// Reset clears all ticket counts and win counters. A stalled receiver holds
// the result in the output register; a following draw runs up to its result
// and waits there until the register frees.
// ----------------------------------------------------------------------------
module lottery_draw_scheduler #(
    parameter int NUM_JOBS  = lds_pkg::NUM_JOBS_DEF,
    parameter int WIN_WIDTH = lds_pkg::WIN_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lds_pkg::TICKETS_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lds_pkg::DRAW_W-1:0]     random_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lds_pkg::INDEX_W-1:0]    winner_index,
    output logic [lds_pkg::TICKET_W-1:0]   winning_ticket,
    output logic [lds_pkg::WINS_OUT_W-1:0] winner_wins,
    output logic                           no_tickets
);
    import lds_pkg::*;

    localparam int CNT_W = $clog2(NUM_JOBS + 1);
    localparam logic [CNT_W-1:0] PASS_END = CNT_W'(NUM_JOBS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DRAW_W-1:0]     draw_reg;
    logic [DRAW_W-1:0]     draw_next;
    logic                  no_tix_reg;
    logic                  no_tix_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [INDEX_W-1:0]    winner_index_reg;
    logic [INDEX_W-1:0]    winner_index_next;
    logic [TICKET_W-1:0]   winning_ticket_reg;
    logic [TICKET_W-1:0]   winning_ticket_next;
    logic [WINS_OUT_W-1:0] winner_wins_reg;
    logic [WINS_OUT_W-1:0] winner_wins_next;
    logic                  no_tickets_reg;
    logic                  no_tickets_next;

    lds_link_t             link [NUM_JOBS+1];
    logic [NUM_JOBS-1:0]   hit;
    logic [WIN_WIDTH-1:0]  wins [NUM_JOBS];
    logic [TICKET_W-1:0]   total;
    logic [TICKET_W-1:0]   ticket;
    logic                  div_start;
    logic                  div_busy;
    logic                  grant;
    logic [INDEX_W-1:0]    sel_index;
    logic [WINS_OUT_W-1:0] sel_wins;

    // row of job cells
    assign link[0] = '0;

    for (genvar i = 0; i < NUM_JOBS; i++)
    begin : g_cell
        lds_cell #(
            .WIN_WIDTH (WIN_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg_we   (cfg_valid && (cfg_index == CFG_IDX_W'(i))),
            .cfg_data (cfg_data),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .ticket   (ticket),
            .grant    (grant),
            .hit      (hit[i]),
            .wins     (wins[i])
        );
    end

    assign total = link[NUM_JOBS].sum;

    // winning ticket
    lds_divmod u_divmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (draw_reg),
        .divisor   (total),
        .busy      (div_busy),
        .remainder (ticket)
    );

    // winner index and win count from the one-hot hit vector
    always_comb
    begin
        sel_index = '0;
        sel_wins  = '0;
        for (int i = 0; i < NUM_JOBS; i++)
        begin
            if (hit[i])
            begin
                sel_index = sel_index | INDEX_W'(i);
                sel_wins  = sel_wins | WINS_OUT_W'(wins[i]);
            end
        end
    end

    // draw sequencer
    always_comb
    begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        draw_next           = draw_reg;
        no_tix_next         = no_tix_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        winner_index_next   = winner_index_reg;
        winning_ticket_next = winning_ticket_reg;
        winner_wins_next    = winner_wins_reg;
        no_tickets_next     = no_tickets_reg;
        div_start           = 1'b0;
        grant               = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    draw_next  = random_value;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PASS_END)
                begin
                    cnt_next = '0;
                    if (total == '0)
                    begin
                        no_tix_next = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        no_tix_next = 1'b0;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cnt_next = '0;
                if (!div_busy)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PASS_END)
                begin
                    cnt_next   = '0;
                    grant      = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    winner_index_next   = no_tix_reg ? '0 : sel_index;
                    winning_ticket_next = no_tix_reg ? '0 : ticket;
                    winner_wins_next    = no_tix_reg ? '0 : sel_wins;
                    no_tickets_next     = no_tix_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            draw_reg           <= '0;
            no_tix_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            winner_index_reg   <= '0;
            winning_ticket_reg <= '0;
            winner_wins_reg    <= '0;
            no_tickets_reg     <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            draw_reg           <= draw_next;
            no_tix_reg         <= no_tix_next;
            out_valid_reg      <= out_valid_next;
            winner_index_reg   <= winner_index_next;
            winning_ticket_reg <= winning_ticket_next;
            winner_wins_reg    <= winner_wins_next;
            no_tickets_reg     <= no_tickets_next;
        end
    end

    // ports
    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign winner_index   = winner_index_reg;
    assign winning_ticket = winning_ticket_reg;
    assign winner_wins    = winner_wins_reg;
    assign no_tickets     = no_tickets_reg;

endmodule

@@ rtl/lds_checker.sv @@
// ----------------------------------------------------------------------------
// lds_checker: port-level checks of the lottery draw scheduler
// Watches the draw and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lds_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [lds_pkg::INDEX_W-1:0]    winner_index,
    input logic [lds_pkg::TICKET_W-1:0]   winning_ticket,
    input logic [lds_pkg::WINS_OUT_W-1:0] winner_wins,
    input logic                           no_tickets
);

    // one draw at a time: no new item right after an accept
    a_one_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("draw accepted while another draw is in flight");

    // a result never appears in the cycle right after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result shown too early after a draw");

    // an empty draw reports all-zero fields
    a_empty_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_tickets) |->
            (winner_index == '0) && (winning_ticket == '0) && (winner_wins == '0))
        else $error("no-tickets result with nonzero fields");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(winner_index) && $stable(winning_ticket)
            && $stable(winner_wins) && $stable(no_tickets))
        else $error("result changed while stalled");

endmodule

bind lottery_draw_scheduler lds_checker u_lds_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .winner_index   (winner_index),
    .winning_ticket (winning_ticket),
    .winner_wins    (winner_wins),
    .no_tickets     (no_tickets)
);
